// File: sv/tfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tfa_pkg;

  localparam int unsigned FACE_W = 16;
  localparam int unsigned VERT_W = 20;
  localparam int unsigned VCNT_W = 21;
  localparam int unsigned KEY_W  = 42;
  localparam int unsigned SLOT_W = 2;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 21'h100000;
  localparam logic [63:0]       HASH_MULT  = 64'h9E3779B97F4A7C15;

  localparam logic [SLOT_W-1:0] SLOT_LO_MID = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_LO_HI  = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_MID_HI = 2'd2;

  typedef struct packed {
    logic [FACE_W-1:0] face_id;
    logic [VERT_W-1:0] corner_a;
    logic [VERT_W-1:0] corner_b;
    logic [VERT_W-1:0] corner_c;
  } face_req_t;

  typedef struct packed {
    logic [FACE_W-1:0] this_face;
    logic              hit_lo_mid;
    logic [FACE_W-1:0] nbr_lo_mid;
    logic [SLOT_W-1:0] nbr_slot_lo_mid;
    logic              hit_lo_hi;
    logic [FACE_W-1:0] nbr_lo_hi;
    logic [SLOT_W-1:0] nbr_slot_lo_hi;
    logic              hit_mid_hi;
    logic [FACE_W-1:0] nbr_mid_hi;
    logic [SLOT_W-1:0] nbr_slot_mid_hi;
    logic              table_overflow;
  } face_res_t;

  // front output: face and lo-mid, lo-hi, mid-hi edge keys
  typedef struct packed {
    logic [FACE_W-1:0]         face;
    logic [2:0][KEY_W-1:0]     key;
  } work_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [FACE_W-1:0] face;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_HASH,
    BK_INDEX,
    BK_READ,
    BK_CHECK
  } back_state_e;

endpackage
`default_nettype wire

// File: sv/tfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

// File: sv/tfa_front.sv
`timescale 1ns / 1ps
`default_nettype none
module tfa_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire tfa_pkg::face_req_t     req_i,
  input  wire logic                   hold_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [20:0]            cfg_data_i,
  input  wire logic                   q_full_i,
  output logic                        q_push_o,
  output tfa_pkg::work_t              q_data_o,
  output logic                        busy_o
);
  import tfa_pkg::*;

  logic              s1_v_q, s1_v_d, s2_v_q, s2_v_d;
  logic [VCNT_W-1:0] vcnt_q;
  logic [FACE_W-1:0] s1_face_q, s2_face_q;
  logic [VERT_W-1:0] lo_q, mid_q, hi_q;
  logic [VERT_W-1:0] a0, b0, a1, b1, lo_d, mid_d, hi_d;
  logic [2:0][KEY_W-1:0] key_q, key_d;
  logic [VCNT_W+VERT_W-1:0] m_lm, m_lh, m_mh;
  logic accept;

  assign busy_o = hold_i | s1_v_q | s2_v_q | q_full_i;
  assign accept = start_i & ~busy_o;

  // three-compare sort network
  always_comb begin
    a0 = (req_i.corner_a > req_i.corner_b) ? req_i.corner_b : req_i.corner_a;
    b0 = (req_i.corner_a > req_i.corner_b) ? req_i.corner_a : req_i.corner_b;
    a1 = (b0 > req_i.corner_c) ? req_i.corner_c : b0;
    hi_d = (b0 > req_i.corner_c) ? b0 : req_i.corner_c;
    b1 = a1;
    lo_d  = (a0 > b1) ? b1 : a0;
    mid_d = (a0 > b1) ? a0 : b1;
  end

  always_comb begin
    m_lm = vcnt_q * mid_q;
    m_lh = vcnt_q * hi_q;
    m_mh = vcnt_q * hi_q;
    key_d[0] = KEY_W'(m_lm) + KEY_W'(lo_q);
    key_d[1] = KEY_W'(m_lh) + KEY_W'(lo_q);
    key_d[2] = KEY_W'(m_mh) + KEY_W'(mid_q);
  end

  always_comb begin
    q_push_o = s2_v_q & ~q_full_i;
    s2_v_d = s2_v_q;
    s1_v_d = s1_v_q;
    if (q_push_o) begin
      s2_v_d = 1'b0;
    end
    if (s1_v_q && !s2_v_d) begin
      s2_v_d = 1'b1;
      s1_v_d = 1'b0;
    end
    if (accept) begin
      s1_v_d = 1'b1;
    end
  end

  assign q_data_o.face = s2_face_q;
  assign q_data_o.key  = key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      vcnt_q <= VCNT_RESET;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      if (cfg_we_i) begin
        vcnt_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_face_q <= req_i.face_id;
      lo_q      <= lo_d;
      mid_q     <= mid_d;
      hi_q      <= hi_d;
    end
    if (s1_v_q && !s2_v_q) begin
      s2_face_q <= s1_face_q;
      key_q     <= key_d;
    end
  end

endmodule
`default_nettype wire

// File: sv/tfa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module tfa_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tfa_pkg::work_t data_i,
  input  wire logic           pop_i,
  output tfa_pkg::work_t      data_o,
  output logic                full_o,
  output logic                empty_o
);
  import tfa_pkg::*;

  work_t      buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = buf_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/tfa_back.sv
`timescale 1ns / 1ps
`default_nettype none
module tfa_back #(
  parameter int unsigned TABLE_DEPTH = 131072
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           clear_i,
  input  wire logic           q_empty_i,
  input  wire tfa_pkg::work_t q_data_i,
  output logic                q_pop_o,
  output logic                clearing_o,
  output logic                strobe_o,
  output tfa_pkg::face_res_t  res_o
);
  import tfa_pkg::*;

  localparam int unsigned SLOTS = 2 * TABLE_DEPTH;
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW    = AW + 20;
  localparam int unsigned H     = (PW + 1) / 2;
  localparam logic [PW-1:0]   MULT_PW = HASH_MULT[PW-1:0];
  localparam logic [PW-H-1:0] MULT_HI = HASH_MULT[PW-H-1:0];

  back_state_e state_q, state_d;
  work_t       cur_q, cur_d;
  logic [1:0]  l_q, l_d;
  logic [AW-1:0] idx_q, idx_d, clr_q, clr_d;
  logic [CW-1:0] edges_q, edges_d;
  logic [PW-1:0] p_lo_q, p_lo_d, sum;
  logic [PW-H-1:0] p_hi_q, p_hi_d;
  logic [PW+KEY_W-1:0] kext;
  logic [PW-1:0] kx;
  face_res_t   res_q, res_d;
  logic        out_q, out_d;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  entry_t      ram_wdata, ram_rdata;
  logic [KEY_W-1:0] cur_key;
  logic        hit, last;

  tfa_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign cur_key = cur_q.key[l_q];
  assign kext    = {{PW{1'b0}}, cur_key};
  assign kx      = kext[PW-1:0];
  assign p_lo_d  = PW'(kx[H-1:0]) * MULT_PW;
  assign p_hi_d  = kx[PW-1:H] * MULT_HI;
  assign sum     = p_lo_q + {p_hi_q, {H{1'b0}}};
  assign hit     = ram_rdata.valid && (ram_rdata.key == cur_key);
  assign last    = (l_q == SLOT_MID_HI);

  assign clearing_o = (state_q == BK_CLEAR);
  assign strobe_o   = out_q;
  assign res_o      = res_q;

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    l_d       = l_q;
    idx_d     = idx_q;
    clr_d     = clr_q;
    edges_d   = edges_q;
    res_d     = res_q;
    out_d     = 1'b0;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = idx_q;
    ram_wdata = '0;
    case (state_q)
      BK_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_q;
        clr_d    = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          l_d     = SLOT_LO_MID;
          res_d   = '0;
          res_d.this_face = q_data_i.face;
          state_d = BK_HASH;
        end
      end
      BK_HASH:  state_d = BK_INDEX;
      BK_INDEX: begin
        idx_d   = sum[PW-1:20];
        state_d = BK_READ;
      end
      BK_READ:  state_d = BK_CHECK;
      BK_CHECK: begin
        if (ram_rdata.valid && !hit) begin
          idx_d   = idx_q + 1'b1;
          state_d = BK_READ;
        end else begin
          if (hit) begin
            case (l_q)
              SLOT_LO_MID: begin
                res_d.hit_lo_mid      = 1'b1;
                res_d.nbr_lo_mid      = ram_rdata.face;
                res_d.nbr_slot_lo_mid = ram_rdata.slot;
              end
              SLOT_LO_HI: begin
                res_d.hit_lo_hi      = 1'b1;
                res_d.nbr_lo_hi      = ram_rdata.face;
                res_d.nbr_slot_lo_hi = ram_rdata.slot;
              end
              default: begin
                res_d.hit_mid_hi      = 1'b1;
                res_d.nbr_mid_hi      = ram_rdata.face;
                res_d.nbr_slot_mid_hi = ram_rdata.slot;
              end
            endcase
          end else if (edges_q < CW'(TABLE_DEPTH)) begin
            ram_we          = 1'b1;
            ram_wdata.valid = 1'b1;
            ram_wdata.key   = cur_key;
            ram_wdata.face  = cur_q.face;
            ram_wdata.slot  = l_q;
            edges_d         = edges_q + 1'b1;
          end else begin
            res_d.table_overflow = 1'b1;
          end
          if (last) begin
            out_d   = 1'b1;
            state_d = BK_IDLE;
          end else begin
            l_d     = l_q + 1'b1;
            state_d = BK_HASH;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
    // a vertex_count write wipes the table
    if (clear_i) begin
      state_d = BK_CLEAR;
      clr_d   = '0;
      edges_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      clr_q   <= '0;
      edges_q <= '0;
      out_q   <= 1'b0;
      l_q     <= SLOT_LO_MID;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      edges_q <= edges_d;
      out_q   <= out_d;
      l_q     <= l_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    p_lo_q <= p_lo_d;
    p_hi_q <= p_hi_d;
  end

endmodule
`default_nettype wire

// File: sv/triangle_face_adjacency.sv
`timescale 1ns / 1ps
`default_nettype none
// triangle face adjacency through a hashed edge table
// request channel: present req_i with start high; it is taken at an edge where
// busy is low. faces must come in the order the mesh defines them.
// result channel: strobe is high for one cycle with res_o holding the three
// neighbour lookups of one face; results leave in request order and cannot
// be held off, so the receiver must take them as they come.
// config: cfg_we_i writes vertex_count and wipes the edge table; write it
// only while no request is in flight.
// the front sorts corners and forms the lo-mid, lo-hi and mid-hi edge keys,
// and a two-entry queue decouples it from the back, which walks them in turn.
// per key the back hashes in its hash and index states, then probes the
// single-port table ram in its read and check states until it finds the key
// or an empty slot; each face starts with a pop of the queue, which the back
// makes only when idle, so it works on one face at a time. the strobe follows
// the check of a face's last key, and each extra probe delays it.
// after reset and after each config write the table is cleared one entry a
// cycle, all 2*TABLE_DEPTH entries, with busy held high.
module triangle_face_adjacency #(
  parameter int unsigned TABLE_DEPTH = 131072
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire tfa_pkg::face_req_t req_i,
  output logic                    strobe,
  output tfa_pkg::face_res_t      res_o,
  input  wire logic               cfg_we_i,
  input  wire logic [20:0]        cfg_data_i
);
  import tfa_pkg::*;

  work_t push_data, pop_data;
  logic  push, pop, full, empty, clearing;

  tfa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req_i),
    .hold_i     (clearing),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_data_o   (push_data),
    .busy_o     (busy)
  );

  tfa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .data_o  (pop_data),
    .full_o  (full),
    .empty_o (empty)
  );

  tfa_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (cfg_we_i),
    .q_empty_i  (empty),
    .q_data_i   (pop_data),
    .q_pop_o    (pop),
    .clearing_o (clearing),
    .strobe_o   (strobe),
    .res_o      (res_o)
  );

endmodule
`default_nettype wire

// File: sv/tfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module tfa_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               strobe,
  input wire tfa_pkg::face_res_t res_o,
  input wire logic               cfg_we_i
);

  // the table wipe must block requests
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("no busy after config write");

  // an accepted request makes the front busy in the next cycle
  a_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("front took two requests in a row");

  // one face needs several table probes
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |=> !strobe)
    else $error("results too close together");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && !res_o.hit_lo_mid |->
      res_o.nbr_lo_mid == '0 && res_o.nbr_slot_lo_mid == '0)
    else $error("neighbour reported on a miss");

endmodule

bind triangle_face_adjacency tfa_checker u_tfa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe   (strobe),
  .res_o    (res_o),
  .cfg_we_i (cfg_we_i)
);
`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import tfa_pkg::*;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [SLOT_W-1:0] slot;
  } edge_rec_t;

  class adjacency_board;
    logic [VCNT_W-1:0]  vcount;
    edge_rec_t          edge_map[logic [63:0]];
    int unsigned        edges_stored;
    face_res_t          pending_faces[$];
    int unsigned        errors;
    int unsigned        depth;

    function new(int unsigned table_depth);
      depth = table_depth;
      vcount = VCNT_RESET;
      edges_stored = 0;
      errors = 0;
    endfunction

    function void set_vcount(logic [VCNT_W-1:0] v);
      vcount = v;
      edge_map.delete();
      edges_stored = 0;
    endfunction

    // sort corners, walk the lo-mid, lo-hi and mid-hi edge keys in slot order
    function void note(face_req_t req);
      logic [VERT_W-1:0] v [3];
      logic [VERT_W-1:0] t;
      logic [63:0]       keys [3];
      logic [SLOT_W-1:0] slot_id [3];
      logic              hit [3];
      logic [FACE_W-1:0] nbr [3];
      logic [SLOT_W-1:0] nslot [3];
      logic              ovf;
      face_res_t         r;
      v[0] = req.corner_a;
      v[1] = req.corner_b;
      v[2] = req.corner_c;
      if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
      if (v[1] > v[2]) begin t = v[1]; v[1] = v[2]; v[2] = t; end
      if (v[0] > v[1]) begin t = v[0]; v[0] = v[1]; v[1] = t; end
      keys[0] = 64'(v[0]) + 64'(vcount) * 64'(v[1]);
      keys[1] = 64'(v[0]) + 64'(vcount) * 64'(v[2]);
      keys[2] = 64'(v[1]) + 64'(vcount) * 64'(v[2]);
      slot_id[0] = SLOT_LO_MID;
      slot_id[1] = SLOT_LO_HI;
      slot_id[2] = SLOT_MID_HI;
      ovf = 1'b0;
      for (int i = 0; i < 3; i++) begin
        if (edge_map.exists(keys[i])) begin
          hit[i] = 1'b1;
          nbr[i] = edge_map[keys[i]].face;
          nslot[i] = edge_map[keys[i]].slot;
        end else begin
          hit[i] = 1'b0;
          nbr[i] = '0;
          nslot[i] = '0;
          if (edges_stored < depth) begin
            edge_map[keys[i]] = '{face: req.face_id, slot: slot_id[i]};
            edges_stored++;
          end else begin
            ovf = 1'b1;
          end
        end
      end
      r.this_face = req.face_id;
      r.hit_lo_mid = hit[0];
      r.nbr_lo_mid = nbr[0];
      r.nbr_slot_lo_mid = nslot[0];
      r.hit_lo_hi = hit[1];
      r.nbr_lo_hi = nbr[1];
      r.nbr_slot_lo_hi = nslot[1];
      r.hit_mid_hi = hit[2];
      r.nbr_mid_hi = nbr[2];
      r.nbr_slot_mid_hi = nslot[2];
      r.table_overflow = ovf;
      pending_faces.insert(pending_faces.size(), r);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check(face_res_t act);
      face_res_t e;
      if (pending_faces.size() == 0) begin
        $error("result for face %0h with no request pending", act.this_face);
        errors++;
        return;
      end
      e = pending_faces.pop_front();
      cmp("this_face", e.this_face, act.this_face);
      cmp("hit_lo_mid", e.hit_lo_mid, act.hit_lo_mid);
      cmp("nbr_lo_mid", e.nbr_lo_mid, act.nbr_lo_mid);
      cmp("nbr_slot_lo_mid", e.nbr_slot_lo_mid, act.nbr_slot_lo_mid);
      cmp("hit_lo_hi", e.hit_lo_hi, act.hit_lo_hi);
      cmp("nbr_lo_hi", e.nbr_lo_hi, act.nbr_lo_hi);
      cmp("nbr_slot_lo_hi", e.nbr_slot_lo_hi, act.nbr_slot_lo_hi);
      cmp("hit_mid_hi", e.hit_mid_hi, act.hit_mid_hi);
      cmp("nbr_mid_hi", e.nbr_mid_hi, act.nbr_mid_hi);
      cmp("nbr_slot_mid_hi", e.nbr_slot_mid_hi, act.nbr_slot_mid_hi);
      cmp("table_overflow", e.table_overflow, act.table_overflow);
    endfunction
  endclass

  localparam int unsigned DEPTH = 131072;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned ITEMS_PER_PHASE = 388;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  face_req_t         req_i = '0;
  logic              strobe;
  face_res_t         res_o;
  logic              cfg_we_i = 1'b0;
  logic [VCNT_W-1:0] cfg_data_i = '0;

  adjacency_board sb = new(DEPTH);

  face_req_t   mesh_hist[$];
  logic [15:0] next_face;
  bit          no_gaps;

  triangle_face_adjacency #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .req_i     (req_i),
    .strobe    (strobe),
    .res_o     (res_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && strobe) sb.check(res_o);
  end

  task automatic send_face(face_req_t req);
    int unsigned gap;
    start <= 1'b1;
    req_i <= req;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note(req);
    mesh_hist.insert(mesh_hist.size(), req);
    if (mesh_hist.size() > 32) void'(mesh_hist.pop_front());
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_corners(logic [19:0] a, logic [19:0] b, logic [19:0] c);
    face_req_t req;
    req.face_id = next_face;
    req.corner_a = a;
    req.corner_b = b;
    req.corner_c = c;
    next_face++;
    send_face(req);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (sb.pending_faces.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_vcount(logic [VCNT_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_vcount(v);
    mesh_hist.delete();
    next_face = '0;
  endtask

  task automatic random_faces(int unsigned n);
    face_req_t   old;
    logic [19:0] p, q, r, t;
    int unsigned sel;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      if (sel <= 5 && mesh_hist.size() > 0) begin
        // neighbour face: reuse one edge of an earlier face
        old = mesh_hist[$urandom_range(0, mesh_hist.size() - 1)];
        case ($urandom_range(0, 2))
          0: begin p = old.corner_a; q = old.corner_b; end
          1: begin p = old.corner_a; q = old.corner_c; end
          default: begin p = old.corner_b; q = old.corner_c; end
        endcase
        r = 20'($urandom_range(0, 63));
      end else if (sel <= 7) begin
        p = 20'($urandom_range(0, 63));
        q = 20'($urandom_range(0, 63));
        r = 20'($urandom_range(0, 63));
      end else if (sel == 8) begin
        p = 20'($urandom);
        q = 20'($urandom);
        r = 20'($urandom);
      end else begin
        p = 20'($urandom_range(0, 63));
        q = p;
        r = ($urandom_range(0, 1) == 0) ? p : 20'($urandom_range(0, 63));
      end
      // shuffle corner order
      if ($urandom_range(0, 1) == 1) begin t = p; p = q; q = t; end
      if ($urandom_range(0, 1) == 1) begin t = q; q = r; r = t; end
      if ($urandom_range(0, 1) == 1) begin t = p; p = r; r = t; end
      if ($urandom_range(0, 15) == 0) next_face = 16'($urandom);
      send_corners(p, q, r);
    end
  endtask

  initial begin
    next_face = '0;
    no_gaps = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, degenerate faces, shared edges
    send_corners(20'd0, 20'd0, 20'd0);
    send_corners(20'd0, 20'd1, 20'd2);
    send_corners(20'd2, 20'd1, 20'd3);
    send_corners(20'd3, 20'd0, 20'd2);
    send_corners(20'd1, 20'd0, 20'd2);
    send_corners(20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_corners(20'hFFFFF, 20'd0, 20'hFFFFE);
    send_corners(20'd5, 20'd5, 20'd9);
    send_corners(20'd9, 20'd5, 20'd9);
    send_corners(20'hFFFFF, 20'hFFFFE, 20'd0);
    next_face = 16'hFFFF;
    send_corners(20'h55555, 20'hAAAAA, 20'hFFFFF);
    send_corners(20'h55555, 20'hAAAAA, 20'd7);
    random_faces(ITEMS_PER_PHASE);
    drain();

    write_vcount(21'd1);
    send_corners(20'd1, 20'd0, 20'd2);
    send_corners(20'd0, 20'd3, 20'd1);
    random_faces(ITEMS_PER_PHASE);
    drain();

    write_vcount(21'd37);
    random_faces(ITEMS_PER_PHASE);
    drain();

    write_vcount(21'h100000);
    send_corners(20'hFFFFF, 20'hFFFFE, 20'hFFFFD);
    random_faces(ITEMS_PER_PHASE);
    drain();

    if (sb.errors == 0 && sb.pending_faces.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
